// ===== hdl/assert_macros.svh =====
// assertion macros used by the normaliser top module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define CHK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("check failed");

`endif

// ===== hdl/v3n_pkg.sv =====
// shared widths and helpers for the vector normaliser
// no dependencies
package v3n_pkg;
  localparam int IN_WIDTH  = 24;
  localparam int FRAC_BITS = 15;
  localparam int OUT_WIDTH = 16;
  localparam int MAG_W     = IN_WIDTH;
  localparam int SUM_W     = 2 * IN_WIDTH + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int QUO_W     = NUM_W;
  localparam logic [FRAC_BITS:0] LIMIT = {1'b0, {FRAC_BITS{1'b1}}};

  // magnitude of a two's complement value
  function automatic logic [MAG_W-1:0] mag_of(input logic [IN_WIDTH-1:0] v);
    logic [IN_WIDTH-1:0] n;
    n = v[IN_WIDTH-1] ? (~v + 1'b1) : v;
    return n;
  endfunction
endpackage

// ===== hdl/v3n_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on v3n_pkg
module v3n_sqrt import v3n_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  s,
  output logic [ROOT_W-1:0] root
);
  logic [SUM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] res  [ROOT_W+1];

  assign rem[0] = s;
  assign res[0] = '0;

  // restoring square root stage: decide one bit from the top
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic [SUM_W+1:0]  trial;
    logic [SUM_W+1:0]  cur;
    logic [SUM_W-1:0]  rem_r;
    logic [ROOT_W-1:0] res_r;
    assign cur   = {2'b00, rem[i]};
    assign trial = ({2'b00, {{(SUM_W-ROOT_W){1'b0}}, res[i]}} << (B + 1))
                 + ({{(SUM_W+1){1'b0}}, 1'b1} << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r <= SUM_W'(cur - trial);
          res_r <= res[i] | (ROOT_W'(1) << B);
        end else begin
          rem_r <= rem[i];
          res_r <= res[i];
        end
      end
    end
    assign rem[i+1] = rem_r;
    assign res[i+1] = res_r;
  end

  assign root = res[ROOT_W];
endmodule

// ===== hdl/v3n_div.sv =====
// pipelined restoring divider with saturation and sign
// depends on v3n_pkg
module v3n_div import v3n_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MAG_W-1:0]      mag,
  input  logic                  neg,
  input  logic [ROOT_W-1:0]     den,
  output logic [OUT_WIDTH-1:0]  q_out
);
  logic [ROOT_W:0]    rem [QUO_W+1];
  logic [NUM_W-1:0]   num [QUO_W+1];
  logic [ROOT_W-1:0]  dv  [QUO_W+1];
  logic               sg  [QUO_W+1];

  assign rem[0] = '0;
  assign num[0] = {mag, {FRAC_BITS{1'b0}}};
  assign dv[0]  = den;
  assign sg[0]  = neg;

  // one quotient bit per stage, collected in the low end of num
  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [ROOT_W+1:0] sh;
    logic [ROOT_W+1:0] df;
    logic [ROOT_W:0]   rem_r;
    logic [NUM_W-1:0]  num_r;
    logic [ROOT_W-1:0] dv_r;
    logic              sg_r;
    assign sh = {rem[i], num[i][NUM_W-1]};
    assign df = sh - {2'b00, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r  <= dv[i];
        sg_r  <= sg[i];
        if (!df[ROOT_W+1]) begin
          rem_r <= df[ROOT_W:0];
          num_r <= {num[i][NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= sh[ROOT_W:0];
          num_r <= {num[i][NUM_W-2:0], 1'b0};
        end
      end
    end
    assign rem[i+1] = rem_r;
    assign num[i+1] = num_r;
    assign dv[i+1]  = dv_r;
    assign sg[i+1]  = sg_r;
  end

  // saturate, apply sign
  logic [FRAC_BITS:0]  sat;
  logic [FRAC_BITS:0]  sgn;
  always_comb begin
    sat = (num[QUO_W] > NUM_W'(LIMIT)) ? LIMIT : num[QUO_W][FRAC_BITS:0];
    sgn = sg[QUO_W] ? (~sat + 1'b1) : sat;
    q_out = OUT_WIDTH'(sgn);
  end
endmodule

// ===== hdl/vector3_unit_normalizer_unit.sv =====
// Three-axis vector normaliser, one sample per cycle unless stalled by out_stall.
// Input channel: x_in, y_in, z_in with in_valid / in_stall.
// Output channel: x_unit, y_unit, z_unit, zero_vector with out_valid / out_stall.
// Each sample is squared and summed (two stages), passes a square root pipeline
// of one stage per root bit (25), then three divider pipelines of one stage per
// quotient bit (39). Throughput is one request per cycle while out_stall does
// not freeze the pipeline; every stage is a register so a new request enters
// while earlier ones are in flight.
// A zero vector gives zero outputs and zero_vector set.
// While out_stall is high and the last stage holds a result the whole
// pipeline freezes, in_stall rises and nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// depends on v3n_pkg, v3n_sqrt, v3n_div, assert_macros.svh
`include "assert_macros.svh"
module vector3_unit_normalizer_unit import v3n_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_WIDTH-1:0]  x_in,
  input  logic [IN_WIDTH-1:0]  y_in,
  input  logic [IN_WIDTH-1:0]  z_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_WIDTH-1:0] x_unit,
  output logic [OUT_WIDTH-1:0] y_unit,
  output logic [OUT_WIDTH-1:0] z_unit,
  output logic                 zero_vector
);
  localparam int LAT = 2 + ROOT_W + QUO_W;

  logic en;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] zr;

  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;

  // valid and zero flags march with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zr <= {zr[LAT-2:0], (x_in == '0) && (y_in == '0) && (z_in == '0)};
    end
  end

  // stage 1: magnitudes and squares
  logic [MAG_W-1:0] mx1, my1, mz1;
  logic             nx1, ny1, nz1;
  logic [2*MAG_W-1:0] sx1, sy1, sz1;
  always_ff @(posedge clk) begin
    if (en) begin
      mx1 <= mag_of(x_in);
      my1 <= mag_of(y_in);
      mz1 <= mag_of(z_in);
      nx1 <= x_in[IN_WIDTH-1];
      ny1 <= y_in[IN_WIDTH-1];
      nz1 <= z_in[IN_WIDTH-1];
      sx1 <= mag_of(x_in) * mag_of(x_in);
      sy1 <= mag_of(y_in) * mag_of(y_in);
      sz1 <= mag_of(z_in) * mag_of(z_in);
    end
  end

  // stage 2: sum of squares
  logic [SUM_W-1:0] s2;
  logic [MAG_W-1:0] mx2, my2, mz2;
  logic             nx2, ny2, nz2;
  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= SUM_W'(sx1) + SUM_W'(sy1) + SUM_W'(sz1);
      mx2 <= mx1; my2 <= my1; mz2 <= mz1;
      nx2 <= nx1; ny2 <= ny1; nz2 <= nz1;
    end
  end

  // axis data delayed alongside the square root
  logic [MAG_W-1:0] dmx [ROOT_W+1];
  logic [MAG_W-1:0] dmy [ROOT_W+1];
  logic [MAG_W-1:0] dmz [ROOT_W+1];
  logic [2:0]       dng [ROOT_W+1];
  assign dmx[0] = mx2;
  assign dmy[0] = my2;
  assign dmz[0] = mz2;
  assign dng[0] = {nx2, ny2, nz2};
  for (genvar i = 0; i < ROOT_W; i++) begin : g_dly
    logic [MAG_W-1:0] a, b, c;
    logic [2:0]       g;
    always_ff @(posedge clk) begin
      if (en) begin
        a <= dmx[i]; b <= dmy[i]; c <= dmz[i]; g <= dng[i];
      end
    end
    assign dmx[i+1] = a;
    assign dmy[i+1] = b;
    assign dmz[i+1] = c;
    assign dng[i+1] = g;
  end

  logic [ROOT_W-1:0] root;
  v3n_sqrt u_sqrt (.clk(clk), .en(en), .s(s2), .root(root));

  // zero root only for a zero vector; divide by one keeps it harmless
  logic [ROOT_W-1:0] den;
  assign den = (root == '0) ? ROOT_W'(1) : root;

  logic [OUT_WIDTH-1:0] qx, qy, qz;
  v3n_div u_div_x (.clk(clk), .en(en), .mag(dmx[ROOT_W]), .neg(dng[ROOT_W][2]),
                   .den(den), .q_out(qx));
  v3n_div u_div_y (.clk(clk), .en(en), .mag(dmy[ROOT_W]), .neg(dng[ROOT_W][1]),
                   .den(den), .q_out(qy));
  v3n_div u_div_z (.clk(clk), .en(en), .mag(dmz[ROOT_W]), .neg(dng[ROOT_W][0]),
                   .den(den), .q_out(qz));

  // output select
  assign out_valid   = vld[LAT-1];
  assign zero_vector = zr[LAT-1];
  assign x_unit      = zr[LAT-1] ? '0 : qx;
  assign y_unit      = zr[LAT-1] ? '0 : qy;
  assign z_unit      = zr[LAT-1] ? '0 : qz;

  `CHK_ALWAYS(a_stall_only_when_full, !in_stall || (out_valid && out_stall))
  `CHK_NEXT(a_hold_when_stalled, out_valid && out_stall,
            out_valid && $stable(x_unit) && $stable(zero_vector))
  `CHK_NEXT(a_enter_tracked, in_valid && !in_stall, vld[0])
endmodule
